// ===== src/cng_pkg.sv =====
// ----------------------------------------------------------------------------
// cng_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, filter coefficients, state memory layout and the
// sequencer state type of the colored noise generator.
// ----------------------------------------------------------------------------
package cng_pkg;

    // Output and state formats.
    localparam int OUTPUT_WIDTH    = 24;
    localparam int STATE_FRAC_BITS = 28;
    localparam int STATE_W         = 32;
    localparam int GEN_W           = 64;
    localparam int WHITE_W         = STATE_FRAC_BITS + 1;
    localparam int WHITE_SHIFT     = GEN_W - 1 - STATE_FRAC_BITS;

    // Datapath widths: multiplier data operand, coefficient operand, product,
    // and the accumulator used for sums of rounded products.
    localparam int DATA_W = 36;
    localparam int COEF_W = 33;
    localparam int PROD_W = DATA_W + COEF_W;
    localparam int ACC_W  = 40;

    localparam int Q_SHIFT   = 30;
    localparam int BLK_SHIFT = 24;
    localparam int BLK_COEF_W = 25;

    localparam logic signed [PROD_W-1:0] Q_HALF   = PROD_W'(1) << (Q_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] BLK_HALF = PROD_W'(1) << (BLK_SHIFT - 1);

    // Output rounding: half an output LSB in state units.
    localparam int OUT_SHIFT = STATE_FRAC_BITS - 20;
    localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'((1 << OUT_SHIFT) >> 1);

    localparam logic signed [ACC_W-1:0] ST_MAX  = ACC_W'((64'sd1 <<< (STATE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ST_MIN  = -ST_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        ACC_W'((64'sd1 <<< (OUTPUT_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((OUTPUT_WIDTH + 7) / 8) * 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKER = 2'd2;

    // Color codes.
    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_PINK  = 2'd1;
    localparam logic [1:0] COLOR_BROWN = 2'd2;

    localparam logic [GEN_W-1:0]      SEED_RESET    = 64'd88172645463325252;
    localparam logic [BLK_COEF_W-1:0] BLOCKER_RESET = 25'd10977;

    // State memory layout: six pole taps, the delay tap, brown level, mean.
    localparam int PINK_POLES = 6;
    localparam int TAP_W      = $clog2(PINK_POLES);
    localparam int MEM_DEPTH  = PINK_POLES + 3;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam logic [MEM_AW-1:0] ADDR_DELAY = MEM_AW'(PINK_POLES);
    localparam logic [MEM_AW-1:0] ADDR_BROWN = MEM_AW'(PINK_POLES + 1);
    localparam logic [MEM_AW-1:0] ADDR_MEAN  = MEM_AW'(PINK_POLES + 2);

    // Coefficients in Q30, rounded from decimal values given in units of 1e-7.
    localparam longint Q_ONE = 64'sd1 <<< Q_SHIFT;
    localparam longint Q_DEN = 10000000;
    localparam longint Q_RND = 5000000;

    localparam logic signed [COEF_W-1:0] K_GAIN0 = COEF_W'((9988600 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_GAIN1 = COEF_W'((9933200 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_GAIN2 = COEF_W'((9690000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_GAIN3 = COEF_W'((8665000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_GAIN4 = COEF_W'((5500000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_GAIN5 =
        COEF_W'(-((7616000 * Q_ONE + Q_RND) / Q_DEN));

    localparam logic signed [COEF_W-1:0] K_IN0 = COEF_W'((555179 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_IN1 = COEF_W'((750759 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_IN2 = COEF_W'((1538520 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_IN3 = COEF_W'((3104856 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_IN4 = COEF_W'((5329522 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_IN5 =
        COEF_W'(-((168980 * Q_ONE + Q_RND) / Q_DEN));

    localparam logic signed [COEF_W-1:0] K_DIRECT    = COEF_W'((5362000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_PINK_OUT  = COEF_W'((1100000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_DELAY     = COEF_W'((1159260 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_LEAK      = COEF_W'((9980000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_BROWN_IN  = COEF_W'((200000 * Q_ONE + Q_RND) / Q_DEN);
    localparam logic signed [COEF_W-1:0] K_BROWN_OUT =
        COEF_W'((35000000 * Q_ONE + Q_RND) / Q_DEN);

    typedef enum logic [4:0] {
        S_IDLE,
        S_PINK_RD,
        S_PINK_M1,
        S_PINK_M2,
        S_PINK_WR,
        S_DLY_RD,
        S_DLY_M,
        S_DLY_WR,
        S_BRN_RD,
        S_BRN_M1,
        S_BRN_M2,
        S_BRN_WR,
        S_BRN_OUT,
        S_LEVEL,
        S_BLK_RD,
        S_BLK_M,
        S_BLK_MUL,
        S_BLK_WR,
        S_DONE
    } t_state;

    function automatic logic signed [COEF_W-1:0] pole_gain(input logic [TAP_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            3'd0: c = K_GAIN0;
            3'd1: c = K_GAIN1;
            3'd2: c = K_GAIN2;
            3'd3: c = K_GAIN3;
            3'd4: c = K_GAIN4;
            default: c = K_GAIN5;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] pole_input(input logic [TAP_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            3'd0: c = K_IN0;
            3'd1: c = K_IN1;
            3'd2: c = K_IN2;
            3'd3: c = K_IN3;
            3'd4: c = K_IN4;
            default: c = K_IN5;
        endcase
        return c;
    endfunction

    // Q30 product rounded half up.
    function automatic logic signed [ACC_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + Q_HALF) >>> Q_SHIFT;
        return t[ACC_W-1:0];
    endfunction

    // Blocker product (2^-24 units) rounded half up.
    function automatic logic signed [ACC_W-1:0] rnd_blk(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + BLK_HALF) >>> BLK_SHIFT;
        return t[ACC_W-1:0];
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] t;
        if (x > ST_MAX) begin
            t = ST_MAX;
        end else if (x < ST_MIN) begin
            t = ST_MIN;
        end else begin
            t = x;
        end
        return t[STATE_W-1:0];
    endfunction

    function automatic logic signed [OUTPUT_WIDTH-1:0] sat_out(
        input logic signed [ACC_W-1:0] x
    );
        logic signed [ACC_W-1:0] t;
        if (x > OUT_MAX) begin
            t = OUT_MAX;
        end else if (x < OUT_MIN) begin
            t = OUT_MIN;
        end else begin
            t = x;
        end
        return t[OUTPUT_WIDTH-1:0];
    endfunction

endpackage

// ===== src/cng_ram.sv =====
// ----------------------------------------------------------------------------
// cng_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cng_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/colored_noise_generator_top.sv =====
// ----------------------------------------------------------------------------
// colored_noise_generator_top: white, pink and brown noise with DC blocker
// A 64-bit xorshift generator feeds a selectable coloring filter whose state
// lives in a small RAM, followed by a one-pole DC blocker and a saturating
// Q4.20 output stage.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Contents
//  s_axis    in         s_axis_tvalid/tready      one tick, tdata[0] = clear_filters
//  m_axis    out        m_axis_tvalid/tready      tdata[23:0] = sample (signed Q4.20)
//  cfg       in         i_cfg_we (no wait)        i_cfg_index, i_cfg_wdata
//
// A tick runs through the sequencer states of its mode, from its transfer to
// the result appearing in the output register, and the next tick can be taken
// in the cycle after that. The pace is set by the single shared multiplier,
// which every filter product passes through in turn, and by the registered
// read of the state RAM.
// Reset loads the seed, sets the registers to their defaults and marks all
// filter state as zero through per-entry valid bits; the block is ready in the
// first cycle after reset. A stalled output holds the sequencer in its last
// state until the waiting sample is transferred; a new tick is taken as soon
// as the sequencer is back at rest, even while a sample still waits.
// ----------------------------------------------------------------------------
module colored_noise_generator_top
    import cng_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Tick input. tdata: [0] clear_filters, [7:1] zero.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // Sample output. tdata: [23:0] sample, upper bits zero.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    // Configuration writes.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_state r_state, n_state;

    // Configuration and generator state.
    logic [GEN_W-1:0]      r_gen;
    logic [1:0]            r_color;
    logic [BLK_COEF_W-1:0] r_coef;

    // Datapath registers.
    logic signed [WHITE_W-1:0] r_white;
    logic signed [DATA_W-1:0]  r_level;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_sum;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [STATE_W-1:0] r_mean;
    logic signed [DATA_W-1:0]  r_diff;
    logic [TAP_W-1:0]          r_tap;
    logic [MEM_AW-1:0]         r_rd_addr;
    logic [MEM_DEPTH-1:0]      r_valid;
    logic                      r_out_valid;
    logic [OUTPUT_WIDTH-1:0]   r_out_data;

    // Control from the sequencer.
    logic                      w_accept;
    logic                      w_ram_we;
    logic [MEM_AW-1:0]         w_ram_waddr;
    logic [STATE_W-1:0]        w_ram_wdata;
    logic                      w_ram_re;
    logic [MEM_AW-1:0]         w_ram_raddr;
    logic [STATE_W-1:0]        w_ram_rdata;
    logic signed [DATA_W-1:0]  w_mul_a;
    logic signed [COEF_W-1:0]  w_mul_b;
    logic                      w_out_load;

    // Combinational helpers.
    logic [GEN_W-1:0]          w_gen_x1, w_gen_x2, w_gen_next;
    logic signed [WHITE_W-1:0] w_white_next;
    logic signed [STATE_W-1:0] w_rd_val;
    logic signed [STATE_W-1:0] w_new_state;
    logic signed [STATE_W-1:0] w_delay_new;
    logic signed [STATE_W-1:0] w_mean_new;
    logic signed [ACC_W-1:0]   w_out_round;
    logic signed [COEF_W-1:0]  w_coef_ext;

    // No tick is taken while reset is held.
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);

    // One xorshift step: shifts 13, 7 and 17.
    assign w_gen_x1     = r_gen ^ (r_gen << 13);
    assign w_gen_x2     = w_gen_x1 ^ (w_gen_x1 >> 7);
    assign w_gen_next   = w_gen_x2 ^ (w_gen_x2 << 17);
    assign w_white_next = WHITE_W'($signed(w_gen_next) >>> WHITE_SHIFT);

    // Entries not written since the last clear read as zero.
    assign w_rd_val    = r_valid[r_rd_addr] ? $signed(w_ram_rdata) : '0;
    assign w_new_state = sat_state(r_acc + rnd_q(r_prod));
    assign w_delay_new = sat_state(rnd_q(r_prod));
    assign w_mean_new  = sat_state(ACC_W'(r_mean) + rnd_blk(r_prod));
    assign w_out_round = (ACC_W'(r_diff) + OUT_HALF) >>> OUT_SHIFT;
    assign w_coef_ext  = $signed({{(COEF_W - BLK_COEF_W){1'b0}}, r_coef});

    cng_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MEM_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, RAM access and multiplier operand selection.
    always_comb begin
        n_state     = r_state;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        w_ram_re    = 1'b0;
        w_ram_raddr = '0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_color == COLOR_PINK) begin
                        n_state = S_PINK_RD;
                    end else if (r_color == COLOR_BROWN) begin
                        n_state = S_BRN_RD;
                    end else begin
                        n_state = S_BLK_RD;
                    end
                end
            end
            S_PINK_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = MEM_AW'(r_tap);
                n_state     = S_PINK_M1;
            end
            S_PINK_M1: begin
                w_mul_a = DATA_W'(w_rd_val);
                w_mul_b = pole_gain(r_tap);
                n_state = S_PINK_M2;
            end
            S_PINK_M2: begin
                w_mul_a = DATA_W'(r_white);
                w_mul_b = pole_input(r_tap);
                n_state = S_PINK_WR;
            end
            S_PINK_WR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = MEM_AW'(r_tap);
                w_ram_wdata = w_new_state;
                n_state     = (r_tap == TAP_W'(PINK_POLES - 1)) ? S_DLY_RD : S_PINK_RD;
            end
            S_DLY_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = ADDR_DELAY;
                w_mul_a     = DATA_W'(r_white);
                w_mul_b     = K_DIRECT;
                n_state     = S_DLY_M;
            end
            S_DLY_M: begin
                w_mul_a = DATA_W'(r_white);
                w_mul_b = K_DELAY;
                n_state = S_DLY_WR;
            end
            S_DLY_WR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = ADDR_DELAY;
                w_ram_wdata = w_delay_new;
                w_mul_a     = DATA_W'(r_sum);
                w_mul_b     = K_PINK_OUT;
                n_state     = S_LEVEL;
            end
            S_BRN_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = ADDR_BROWN;
                n_state     = S_BRN_M1;
            end
            S_BRN_M1: begin
                w_mul_a = DATA_W'(w_rd_val);
                w_mul_b = K_LEAK;
                n_state = S_BRN_M2;
            end
            S_BRN_M2: begin
                w_mul_a = DATA_W'(r_white);
                w_mul_b = K_BROWN_IN;
                n_state = S_BRN_WR;
            end
            S_BRN_WR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = ADDR_BROWN;
                w_ram_wdata = w_new_state;
                n_state     = S_BRN_OUT;
            end
            S_BRN_OUT: begin
                w_mul_a = DATA_W'(r_acc);
                w_mul_b = K_BROWN_OUT;
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                n_state = S_BLK_RD;
            end
            S_BLK_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = ADDR_MEAN;
                n_state     = S_BLK_M;
            end
            S_BLK_M: begin
                n_state = S_BLK_MUL;
            end
            S_BLK_MUL: begin
                w_mul_a = r_diff;
                w_mul_b = w_coef_ext;
                n_state = S_BLK_WR;
            end
            S_BLK_WR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = ADDR_MEAN;
                w_ram_wdata = w_mean_new;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    // Control state: configuration, generator, valid bits, output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= SEED_RESET;
            r_color     <= COLOR_WHITE;
            r_coef      <= BLOCKER_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_COLOR) begin
                r_color <= i_cfg_wdata[1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_BLOCKER) begin
                r_coef <= i_cfg_wdata[BLK_COEF_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_SEED) begin
                r_gen <= i_cfg_wdata;
            end else if (w_accept) begin
                r_gen <= w_gen_next;
            end

            // A clear is applied before the tick runs, so it wins over writes.
            if (w_accept && s_axis_tdata[0]) begin
                r_valid <= '0;
            end else if (w_ram_we) begin
                r_valid[w_ram_waddr] <= 1'b1;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_ram_re) begin
            r_rd_addr <= w_ram_raddr;
        end
        if (w_out_load) begin
            r_out_data <= sat_out(w_out_round);
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_white <= w_white_next;
                    r_level <= DATA_W'(w_white_next);
                    r_sum   <= '0;
                    r_tap   <= '0;
                end
            end
            S_PINK_M2, S_BRN_M2: begin
                r_acc <= rnd_q(r_prod);
            end
            S_PINK_WR: begin
                r_sum <= r_sum + ACC_W'(w_new_state);
                r_tap <= r_tap + TAP_W'(1);
            end
            S_DLY_M: begin
                // Old delay tap and the direct path join the pole sum.
                r_sum <= r_sum + ACC_W'(w_rd_val) + rnd_q(r_prod);
            end
            S_BRN_WR: begin
                r_acc <= ACC_W'(w_new_state);
            end
            S_LEVEL: begin
                r_level <= DATA_W'(rnd_q(r_prod));
            end
            S_BLK_M: begin
                r_mean <= w_rd_val;
                r_diff <= r_level - DATA_W'(w_rd_val);
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // A tick with the clear flag leaves every state entry reading as zero.
    a_clear_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tdata[0]) |=> (r_valid == '0))
        else $error("filter state not cleared after clear tick");

    // The sequencer never reads and writes the same RAM entry in one cycle.
    a_ram_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && w_ram_re) |-> (w_ram_waddr != w_ram_raddr))
        else $error("state RAM read and write collide");

    // An accepted tick always starts work on the next cycle.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted tick did not start");

    // Pole tap index stays inside the pole bank.
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PINK_RD) |-> (r_tap < TAP_W'(PINK_POLES)))
        else $error("pole tap index out of range");

endmodule

// ===== verif/colored_noise_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colored_noise_generator_top_tb: self-checking testbench for the noise block
// Sends sample ticks over the input stream and compares every output sample
// with a bit-exact fixed-point model of the xorshift generator, the pink and
// brown coloring filters and the DC blocker. Directed ticks cover defaults,
// each color, the unused color code, zero and all-ones seeds and the blocker
// coefficient extremes. Random phases then change the registers while the
// block is idle, with random gaps on both streams and two long output stalls.
// ----------------------------------------------------------------------------
module colored_noise_generator_top_tb
    import cng_pkg::*;
();

    // Color code that the block does not define; it must behave as white.
    localparam logic [1:0] COLOR_UNUSED = 2'd3;

    localparam int  RESET_CYCLES   = 12;
    // Pink mode is the slowest per tick, and this comfortably covers a tick
    // that is still in flight when the last expected sample shows up.
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  RANDOM_TICKS   = 1300;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  WATCHDOG_LIMIT = 5000;

    localparam longint HALF_Q30   = 64'sd1 <<< 29;
    localparam longint HALF_BLOCK = 64'sd1 <<< 23;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    colored_noise_generator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Ticks waiting to be sent (each entry is the clear_filters flag) and the
    // samples predicted for ticks that the block has already taken.
    logic                           tick_queue[$];
    logic signed [OUTPUT_WIDTH-1:0] sample_queue[$];

    int error_count = 0;

    // ------------------------------------------------------------------------
    // Fixed-point model of the generator and its filters.
    // ------------------------------------------------------------------------
    logic [1:0]            model_color;
    logic [GEN_W-1:0]      model_word;
    logic [BLK_COEF_W-1:0] model_coef;
    longint                model_tap[7];
    longint                model_brown;
    longint                model_mean;

    // Decimal coefficient in units of 1e-7, rounded to Q30.
    function automatic longint q30(input longint units);
        return (units * 64'sd1073741824 + 64'sd5000000) / 64'sd10000000;
    endfunction

    // Q30 product, rounded half up.
    function automatic longint mul_q30(input longint x, input longint c);
        return (x * c + HALF_Q30) >>> 30;
    endfunction

    function automatic longint clamp_bits(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    // Feedback gain or input gain of one of the six pink poles.
    function automatic longint pole_coef(input int idx, input bit feed);
        longint c;
        case (idx)
            0:       c = feed ? q30(555179)   : q30(9988600);
            1:       c = feed ? q30(750759)   : q30(9933200);
            2:       c = feed ? q30(1538520)  : q30(9690000);
            3:       c = feed ? q30(3104856)  : q30(8665000);
            4:       c = feed ? q30(5329522)  : q30(5500000);
            default: c = feed ? -q30(168980)  : -q30(7616000);
        endcase
        return c;
    endfunction

    function automatic void clear_filter_state();
        for (int k = 0; k < 7; k++) begin
            model_tap[k] = 0;
        end
        model_brown = 0;
        model_mean  = 0;
    endfunction

    function automatic void reset_noise_model();
        model_color = COLOR_WHITE;
        model_word  = SEED_RESET;
        model_coef  = BLOCKER_RESET;
        clear_filter_state();
    endfunction

    // Advances the model by one tick and returns the sample it produces.
    function automatic logic signed [OUTPUT_WIDTH-1:0] advance_noise(input logic clear);
        longint white;
        longint level;
        longint diff;
        longint total;
        longint rounded;
        if (clear) begin
            clear_filter_state();
        end

        model_word = model_word ^ (model_word << 13);
        model_word = model_word ^ (model_word >> 7);
        model_word = model_word ^ (model_word << 17);
        white = $signed(model_word) >>> (GEN_W - 1 - STATE_FRAC_BITS);

        if (model_color == COLOR_PINK) begin
            total = 0;
            for (int k = 0; k < 6; k++) begin
                model_tap[k] = clamp_bits(mul_q30(model_tap[k], pole_coef(k, 1'b0)) +
                                          mul_q30(white, pole_coef(k, 1'b1)), 32);
                total += model_tap[k];
            end
            total += model_tap[6] + mul_q30(white, q30(5362000));
            level = mul_q30(total, q30(1100000));
            // The delay tap is updated after it has fed this tick's sum.
            model_tap[6] = clamp_bits(mul_q30(white, q30(1159260)), 32);
        end else if (model_color == COLOR_BROWN) begin
            model_brown = clamp_bits(mul_q30(model_brown, q30(9980000)) +
                                     mul_q30(white, q30(200000)), 32);
            level = mul_q30(model_brown, q30(35000000));
        end else begin
            level = white;
        end

        diff = level - model_mean;
        model_mean = clamp_bits(model_mean +
            ((longint'(model_coef) * diff + HALF_BLOCK) >>> 24), 32);

        rounded = (diff + (64'sd1 <<< (STATE_FRAC_BITS - 21))) >>> (STATE_FRAC_BITS - 20);
        rounded = clamp_bits(rounded, OUTPUT_WIDTH);
        return rounded[OUTPUT_WIDTH-1:0];
    endfunction

    // Idle length for either stream: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            n = 0;
        end else if (r < 88) begin
            n = $urandom_range(1, 3);
        end else if (r < 97) begin
            n = $urandom_range(4, 20);
        end else begin
            n = $urandom_range(30, 150);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // Tick driver. An offered tick stays on the bus until it is transferred;
    // the expected sample is computed from the flag that was actually sent.
    // ------------------------------------------------------------------------
    int   send_gap   = 0;
    int   send_burst = 0;
    logic tick_taken;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            tick_taken = s_axis_tvalid && s_axis_tready;
            if (tick_taken) begin
                sample_queue.push_back(advance_noise(s_axis_tdata[0]));
                tick_queue.delete(0);
                // A run of back-to-back ticks now and then, otherwise a random gap.
                if (send_burst > 0) begin
                    send_burst--;
                    send_gap = 0;
                end else if ($urandom_range(0, 29) == 0) begin
                    send_burst = $urandom_range(20, 60);
                    send_gap   = 0;
                end else begin
                    send_gap = idle_len();
                end
            end

            if (s_axis_tvalid && !tick_taken) begin
                // The offer is held until the block takes it.
            end else if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, tick_queue[0]};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample monitor. Checks each transfer against the oldest prediction and
    // applies random back-pressure. Twice during the run it refuses samples
    // for a long stretch while ticks keep coming, so the block has to stall
    // its input.
    // ------------------------------------------------------------------------
    int samples_seen = 0;
    int hold_left    = 0;
    int recv_stall   = 0;
    int recv_burst   = 0;
    logic signed [OUTPUT_WIDTH-1:0] sample_want;
    logic signed [OUTPUT_WIDTH-1:0] sample_got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                samples_seen++;
                sample_got = m_axis_tdata[OUTPUT_WIDTH-1:0];
                if (sample_queue.size() == 0) begin
                    $error("sample transfer %0d with no expected sample, actual %0d",
                           samples_seen, sample_got);
                    error_count++;
                end else begin
                    sample_want = sample_queue.pop_front();
                    if (sample_got !== sample_want) begin
                        $error("sample mismatch at transfer %0d: expected %0d, actual %0d",
                               samples_seen, sample_want, sample_got);
                        error_count++;
                    end
                end
                if (samples_seen == 150 || samples_seen == 800) begin
                    hold_left = HOLD_CYCLES;
                end
            end

            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (recv_burst > 0) begin
                    recv_burst--;
                end else if ($urandom_range(0, 49) == 0) begin
                    recv_burst = $urandom_range(30, 100);
                end else if ($urandom_range(0, 3) == 0) begin
                    recv_stall = idle_len();
                end
            end
        end
    end

    // Ends the run if neither stream moves for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Register writes and phase control.
    // ------------------------------------------------------------------------

    // One register write; the model follows at once, since the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_COLOR:   model_color = value[1:0];
            REG_SEED:    model_word  = value;
            REG_BLOCKER: model_coef  = value[BLK_COEF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued tick has been sent and its sample checked.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (tick_queue.size() != 0 || sample_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_ticks(input int count, input int clear_pct);
        for (int k = 0; k < count; k++) begin
            tick_queue.push_back($urandom_range(0, 99) < clear_pct);
        end
    endtask

    function automatic logic [1:0] pick_color();
        int r;
        logic [1:0] c;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            c = COLOR_WHITE;
        end else if (r < 6) begin
            c = COLOR_PINK;
        end else if (r < 9) begin
            c = COLOR_BROWN;
        end else begin
            c = COLOR_UNUSED;
        end
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] pick_seed();
        int r;
        logic [CFG_W-1:0] s;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            s = '0;
        end else if (r == 1) begin
            s = '1;
        end else begin
            s = {$urandom, $urandom};
        end
        return s;
    endfunction

    // Mostly realistic blocker gains, sometimes the edges and beyond unity.
    function automatic logic [CFG_W-1:0] pick_coef();
        int r;
        logic [CFG_W-1:0] c;
        r = $urandom_range(0, 9);
        case (r)
            0:       c = '0;
            1:       c = 64'd1 << 24;
            2:       c = (64'd1 << BLK_COEF_W) - 1;
            3:       c = CFG_W'($urandom_range(0, (1 << BLK_COEF_W) - 1));
            default: c = CFG_W'($urandom_range(1, 100000));
        endcase
        return c;
    endfunction

    int random_sent;
    int phase_len;

    initial begin
        reset_noise_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset, including a clear on untouched state.
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        wait_drained();

        // Pink filter with a clear part way through.
        write_reg(REG_COLOR, CFG_W'(COLOR_PINK));
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_drained();

        // Brown integrator, again with a clear.
        write_reg(REG_COLOR, CFG_W'(COLOR_BROWN));
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        wait_drained();

        // The unused color code falls back to white.
        write_reg(REG_COLOR, CFG_W'(COLOR_UNUSED));
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        wait_drained();

        // A zero seed locks the generator at zero.
        write_reg(REG_COLOR, CFG_W'(COLOR_WHITE));
        write_reg(REG_SEED, '0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_drained();

        // All-ones seed in brown mode with the blocker switched off.
        write_reg(REG_SEED, '1);
        write_reg(REG_BLOCKER, '0);
        write_reg(REG_COLOR, CFG_W'(COLOR_BROWN));
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_drained();

        // Largest coefficient: the tracked mean overshoots.
        write_reg(REG_BLOCKER, (64'd1 << BLK_COEF_W) - 1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_drained();

        // Unity coefficient in pink mode.
        write_reg(REG_BLOCKER, 64'd1 << 24);
        write_reg(REG_COLOR, CFG_W'(COLOR_PINK));
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        wait_drained();

        // Random phases, each with its own register setting.
        random_sent = 0;
        while (random_sent < RANDOM_TICKS) begin
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_COLOR, CFG_W'(pick_color()));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_SEED, pick_seed());
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_BLOCKER, pick_coef());
            end
            phase_len = $urandom_range(60, 180);
            queue_ticks(phase_len, 4);
            random_sent += phase_len;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
